// ===== src/lfnc_pkg.sv =====
package lfnc_pkg;

   localparam logic [7:0] CharCr = 8'h0D;
   localparam logic [7:0] CharLf = 8'h0A;

   // words one input byte can produce at most
   localparam int MaxWords = 3;
   localparam int WordIdxW = $clog2(MaxWords);
   localparam int WordCntW = $clog2(MaxWords + 1);

   // bundle queue between front and back
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // csr register indexes
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 2;
   localparam logic [CsrIdxW-1:0] CsrCrlfMode      = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrConvertEnable = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrNativeBreak   = 2'd2;

   // native break codes
   localparam logic [1:0] NativeLf = 2'd0;
   localparam logic [1:0] NativeCr = 2'd1;

   typedef enum logic [1:0] {
      TERM_CR   = 2'd0,
      TERM_LF   = 2'd1,
      TERM_CRLF = 2'd2
   } term_kind_type;

   typedef struct packed {
      logic [WordCntW-1:0]          count;
      logic [MaxWords-1:0][7:0]     bytes;
      logic [MaxWords-1:0]          ends;
   } bundle_type;

   function automatic term_kind_type convert_kind(term_kind_type kind, logic has_text,
                                                  logic conv, logic [1:0] nb);
      term_kind_type res;
      term_kind_type nat;
      res = kind;
      nat = (nb == NativeCr) ? TERM_CR : TERM_LF;
      if (conv) begin
         if (nb[1]) begin
            if (kind == TERM_CR)
               res = TERM_CRLF;
            else if (kind == TERM_LF && has_text)
               res = TERM_CRLF;
         end else begin
            if (kind == TERM_CRLF)
               res = nat;
            else if (has_text && kind != nat)
               res = nat;
         end
      end
      return res;
   endfunction

   // append one word, dropped once the bundle is full
   function automatic bundle_type add_word(bundle_type b, logic [7:0] value, logic last);
      bundle_type r;
      r = b;
      if (b.count < WordCntW'(MaxWords)) begin
         r.bytes[b.count[WordIdxW-1:0]] = value;
         r.ends[b.count[WordIdxW-1:0]]  = last;
         r.count = b.count + WordCntW'(1);
      end
      return r;
   endfunction

   function automatic bundle_type add_kind(bundle_type b, term_kind_type kind);
      bundle_type r;
      r = b;
      case (kind)
         TERM_CRLF: begin
            r = add_word(r, CharCr, 1'b0);
            r = add_word(r, CharLf, 1'b1);
         end
         TERM_CR: r = add_word(r, CharCr, 1'b1);
         default: r = add_word(r, CharLf, 1'b1);
      endcase
      return r;
   endfunction

endpackage

// ===== src/line_framer_newline_convert_core.sv =====
// line framer with newline conversion
//
// input channel: req_push / req_full, one text byte per word on req_in_byte.
// a word is taken on a clock edge with req_push high and req_full low.
// result channel: rsp_empty / rsp_pop; the oldest word sits on rsp_out_byte
// and rsp_line_end while rsp_empty is low, and leaves on an edge with rsp_pop.
// rsp_line_end marks the last byte of each finished line's terminator.
// csr port: csr_write_en, csr_index, csr_wdata; 0 crlf_mode, 1 convert_enable,
// 2 native_break. write only while the block is idle.
//
// a taken byte's words pass through the bundle queue registers to the result side.
// throughput: one input byte per cycle while req_full is low; the result side
// moves one word per cycle while rsp_pop is high, so a byte that expands
// to two or three words holds the result side longer; a four-deep bundle
// queue absorbs this. a cr in crlf mode is held until the next byte arrives.
// reset: queue empty, no cr held, crlf_mode 1, conversion off, native lf.
// when the receiver stalls the queue fills and req_full rises; nothing is lost.
module line_framer_newline_convert_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [7:0]                    req_in_byte,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_line_end,
   input  logic                          csr_write_en,
   input  logic [lfnc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [lfnc_pkg::CsrDataW-1:0] csr_wdata
);
   import lfnc_pkg::*;

   logic       accept;
   logic       push;
   bundle_type push_bundle;
   logic       q_valid;
   bundle_type q_head;
   logic       q_pop;

   // front side takes a byte whenever req_push is high and the queue has room
   assign accept = req_push && !req_full;

   lfnc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push         (push),
      .bundle       (push_bundle)
   );

   // bundles of one to three words per taken byte
   lfnc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_bundle),
      .pop       (q_pop),
      .full      (req_full),
      .valid     (q_valid),
      .head      (q_head)
   );

   // back side walks the head bundle one word per pop
   lfnc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (q_valid),
      .head         (q_head),
      .rsp_pop      (rsp_pop),
      .head_pop     (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_line_end (rsp_line_end)
   );

endmodule

// ===== src/lfnc_front.sv =====
module lfnc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [7:0]                    in_byte,
   input  logic                          csr_write_en,
   input  logic [lfnc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [lfnc_pkg::CsrDataW-1:0] csr_wdata,
   output logic                          push,
   output lfnc_pkg::bundle_type          bundle
);
   import lfnc_pkg::*;

   logic       crlf_mode_ff, crlf_mode_in;
   logic       convert_enable_ff, convert_enable_in;
   logic [1:0] native_break_ff, native_break_in;
   logic       cr_pending_ff, cr_pending_in;
   logic       line_has_text_ff, line_has_text_in;

   bundle_type bnd;
   logic       has;
   logic       pend;
   logic       done;

   always_comb begin
      crlf_mode_in      = crlf_mode_ff;
      convert_enable_in = convert_enable_ff;
      native_break_in   = native_break_ff;
      if (csr_write_en) begin
         case (csr_index)
            CsrCrlfMode:      crlf_mode_in      = csr_wdata[0];
            CsrConvertEnable: convert_enable_in = csr_wdata[0];
            CsrNativeBreak:   native_break_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // classify the byte and build its bundle of output words
   always_comb begin
      bnd  = '0;
      has  = line_has_text_ff;
      pend = cr_pending_ff;
      done = 1'b0;
      if (cr_pending_ff) begin
         pend = 1'b0;
         if (in_byte == CharLf) begin
            bnd  = add_kind(bnd, convert_kind(TERM_CRLF, has, convert_enable_ff,
                                              native_break_ff));
            has  = 1'b0;
            done = 1'b1;
         end else begin
            bnd = add_kind(bnd, convert_kind(TERM_CR, has, convert_enable_ff,
                                             native_break_ff));
            has = 1'b0;
         end
      end
      if (!done) begin
         if (in_byte == CharCr) begin
            if (crlf_mode_ff) begin
               pend = 1'b1;
            end else begin
               bnd = add_kind(bnd, convert_kind(TERM_CR, has, convert_enable_ff,
                                                native_break_ff));
               has = 1'b0;
            end
         end else if (in_byte == CharLf) begin
            bnd = add_kind(bnd, convert_kind(TERM_LF, has, convert_enable_ff,
                                             native_break_ff));
            has = 1'b0;
         end else begin
            bnd = add_word(bnd, in_byte, 1'b0);
            has = 1'b1;
         end
      end
   end

   assign cr_pending_in    = accept ? pend : cr_pending_ff;
   assign line_has_text_in = accept ? has  : line_has_text_ff;

   assign push   = accept && (bnd.count != '0);
   assign bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         crlf_mode_ff      <= 1'b1;
         convert_enable_ff <= 1'b0;
         native_break_ff   <= NativeLf;
         cr_pending_ff     <= 1'b0;
         line_has_text_ff  <= 1'b0;
      end else begin
         crlf_mode_ff      <= crlf_mode_in;
         convert_enable_ff <= convert_enable_in;
         native_break_ff   <= native_break_in;
         cr_pending_ff     <= cr_pending_in;
         line_has_text_ff  <= line_has_text_in;
      end
   end

endmodule

// ===== src/lfnc_queue.sv =====
module lfnc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  lfnc_pkg::bundle_type push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 valid,
   output lfnc_pkg::bundle_type head
);
   import lfnc_pkg::*;

   bundle_type           mem_ff [QDepth];
   logic [QPtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full    = (count_ff == QCntW'(QDepth));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign head    = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + QPtrW'(1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_ff + QPtrW'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + QCntW'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - QCntW'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/lfnc_back.sv =====
module lfnc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  lfnc_pkg::bundle_type head,
   input  logic                 rsp_pop,
   output logic                 head_pop,
   output logic                 rsp_empty,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_line_end
);
   import lfnc_pkg::*;

   logic [WordIdxW-1:0] idx_ff, idx_in;
   logic                take;
   logic                last_word;

   assign rsp_empty    = !head_valid;
   assign rsp_out_byte = head.bytes[idx_ff];
   assign rsp_line_end = head.ends[idx_ff];

   assign take      = rsp_pop && head_valid;
   assign last_word = (WordCntW'(idx_ff) + WordCntW'(1)) == head.count;
   assign head_pop  = take && last_word;

   always_comb begin
      idx_in = idx_ff;
      if (take)
         idx_in = last_word ? '0 : idx_ff + WordIdxW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset)
         idx_ff <= '0;
      else
         idx_ff <= idx_in;
   end

endmodule

// ===== src/lfnc_checker.sv =====
module lfnc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_push,
   input logic                          req_full,
   input logic [7:0]                    req_in_byte,
   input logic                          rsp_empty,
   input logic                          rsp_pop,
   input logic [7:0]                    rsp_out_byte,
   input logic                          rsp_line_end
);
   import lfnc_pkg::*;

   // reset leaves nothing to deliver
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   // reset leaves room for input
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input side full after reset");

   // any byte other than cr always yields at least one word
   a_byte_yields: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_in_byte != CharCr) |=> !rsp_empty)
      else $error("taken byte produced no result");

   // a waiting word holds until it is popped
   a_word_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_line_end)))
      else $error("waiting word changed before pop");

endmodule

bind line_framer_newline_convert_core lfnc_checker u_checker (.*);
